### sv/ccmt_pkg.sv
`default_nettype none
package ccmt_pkg;

  localparam int AMOUNT_LIMIT = 1024;
  localparam int COIN_KINDS   = 6;

  localparam int ADDR_W  = $clog2(AMOUNT_LIMIT);
  localparam int COST_W  = 11;
  localparam int KIND_W  = $clog2(COIN_KINDS + 1);
  localparam int SUM_W   = 19;
  localparam int OFF_W   = ADDR_W + 9;
  localparam int TOTAL_W = COST_W + 1;

  // Table entry that no coin combination reaches.
  localparam logic [COST_W-1:0] UNREACHED = '1;
  localparam logic [COST_W-1:0] MIN_COINS_MAX = '1;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NO_PAY   = 2'd1;
  localparam logic [1:0] STATUS_TOO_MUCH = 2'd2;

  localparam logic [7:0] COIN_RESET [6] = '{8'd5, 8'd10, 8'd20, 8'd50, 8'd100, 8'd200};

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [COST_W-1:0] cost_t;

endpackage
`default_nettype wire

### sv/ccmt_ram.sv
`default_nettype none
module ccmt_ram
  import ccmt_pkg::*;
(
  input  wire   clk,
  input  wire   we,
  input  addr_t waddr,
  input  cost_t wdata,
  input  addr_t raddr_a,
  output cost_t rdata_a,
  input  addr_t raddr_b,
  output cost_t rdata_b
);

  cost_t mem [AMOUNT_LIMIT];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
`default_nettype wire

### sv/coin_change_min_total_top.sv
`default_nettype none
// Minimum-coin payment with change, one query at a time.
//
// A query arrives on the slave stream (s_tvalid/s_tready/s_tdata) and carries
// the held count of each of the six coin kinds and a target amount. The result
// leaves on the master stream: m_tdata holds the fewest coins paid plus change
// received, m_tuser the status (ok, no exact payment, holdings too large).
// The user must write coin denominations over the APB port only while no query
// is at work; the block itself does not enforce this.
// Each query rebuilds an unbounded change table and a bounded payment table in
// two 1024-entry synchronous RAMs by read-modify-write, then scans both. When
// holdings are too large or short of the target, the result skips the tables;
// otherwise the block clears both tables, fills the change table one amount at
// a time per denomination, fills the payment table for every amount up to the
// held total per kind, trying every coin count, and then scans each amount
// from the target up to the held total. The payment table with its loop over
// coin counts takes the longest, most of all for large holdings of the
// smallest coins.
// A new query is taken only once the previous result sits in the output
// register, so a stalled receiver holds one finished result while the next
// query is computed; the block then waits until that result is taken.
// Reset restores the default denominations and empties the output register.
module coin_change_min_total_top
  import ccmt_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  // Query: [7:0] count_kind1 ... [47:40] count_kind6, [57:48] target_amount.
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [63:0] s_tdata,
  // Result: [10:0] min_coins.
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [15:0] m_tdata,
  // Result kind: [1:0] status.
  output logic [1:0]  m_tuser,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [4:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SUM     = 4'd1;
  localparam logic [3:0] S_CHECK   = 4'd2;
  localparam logic [3:0] S_INIT    = 4'd3;
  localparam logic [3:0] S_CH_KIND = 4'd4;
  localparam logic [3:0] S_CH_RD   = 4'd5;
  localparam logic [3:0] S_CH_WR   = 4'd6;
  localparam logic [3:0] S_PY_KIND = 4'd7;
  localparam logic [3:0] S_PY_RD0  = 4'd8;
  localparam logic [3:0] S_PY_LD   = 4'd9;
  localparam logic [3:0] S_PY_K    = 4'd10;
  localparam logic [3:0] S_PY_ACC  = 4'd11;
  localparam logic [3:0] S_SC_RD   = 4'd12;
  localparam logic [3:0] S_SC_ACC  = 4'd13;
  localparam logic [3:0] S_FIN     = 4'd14;
  localparam logic [3:0] S_DONE    = 4'd15;

  localparam addr_t LAST_ADDR = ADDR_W'(AMOUNT_LIMIT - 1);

  logic [3:0]         state;
  logic [7:0]         coin_value [COIN_KINDS];
  logic [7:0]         count [COIN_KINDS];
  logic [9:0]         target;
  logic [SUM_W-1:0]   sum;
  logic [KIND_W-1:0]  kind;
  addr_t              j;
  logic [8:0]         k;
  logic [OFF_W-1:0]   off;
  cost_t              best;
  logic [TOTAL_W-1:0] total;
  cost_t              res_coins;
  logic [1:0]         res_status;

  // Change table ports.
  logic  ch_we;
  addr_t ch_waddr, ch_raddr_a, ch_raddr_b;
  cost_t ch_wdata, ch_rdata_a, ch_rdata_b;
  // Payment table ports.
  logic  py_we;
  addr_t py_waddr, py_raddr;
  cost_t py_wdata, py_rdata;

  logic [7:0]         a;
  logic [7:0]         c;
  addr_t              top;
  addr_t              tgt;
  logic [TOTAL_W-1:0] cand;
  logic [TOTAL_W-1:0] scan_sum;

  assign a   = coin_value[kind];
  assign c   = count[kind];
  assign top = sum[ADDR_W-1:0];
  assign tgt = ADDR_W'(target);

  assign cand     = {1'b0, py_rdata} + TOTAL_W'(k);
  assign scan_sum = {1'b0, py_rdata} + {1'b0, ch_rdata_b};

  ccmt_ram u_change (
    .clk     (clk),
    .we      (ch_we),
    .waddr   (ch_waddr),
    .wdata   (ch_wdata),
    .raddr_a (ch_raddr_a),
    .rdata_a (ch_rdata_a),
    .raddr_b (ch_raddr_b),
    .rdata_b (ch_rdata_b)
  );

  ccmt_ram u_pay (
    .clk     (clk),
    .we      (py_we),
    .waddr   (py_waddr),
    .wdata   (py_wdata),
    .raddr_a (py_raddr),
    .rdata_a (py_rdata),
    .raddr_b (py_raddr),
    .rdata_b ()
  );

  // Memory port steering. Port A of the change table reads the amount one
  // coin lower, port B the entry being updated or the scanned change amount.
  always_comb begin
    ch_we      = 1'b0;
    ch_waddr   = j;
    ch_wdata   = UNREACHED;
    ch_raddr_a = j - ADDR_W'(a);
    ch_raddr_b = j;
    py_we      = 1'b0;
    py_waddr   = j;
    py_wdata   = best;
    py_raddr   = j;
    unique case (state)
      S_INIT: begin
        ch_we    = 1'b1;
        py_we    = 1'b1;
        ch_wdata = (j == '0) ? '0 : UNREACHED;
        py_wdata = (j == '0) ? '0 : UNREACHED;
      end
      S_CH_WR: begin
        ch_we    = (ch_rdata_a != UNREACHED) && ((ch_rdata_a + COST_W'(1)) < ch_rdata_b);
        ch_wdata = ch_rdata_a + COST_W'(1);
      end
      S_PY_K: begin
        py_raddr = j - off[ADDR_W-1:0];
        py_we    = !((k <= {1'b0, c}) && (off <= OFF_W'(j)));
      end
      S_SC_RD: begin
        ch_raddr_b = j - tgt;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      for (int i = 0; i < COIN_KINDS; i++) begin
        coin_value[i] <= (i < 6) ? COIN_RESET[i] : 8'd0;
      end
    end else begin
      if (psel && penable && pwrite && (int'(paddr[4:2]) < COIN_KINDS)) begin
        coin_value[paddr[4:2]] <= pwdata[7:0];
      end
      // In the done state the output register is reloaded instead.
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            for (int i = 0; i < COIN_KINDS; i++) begin
              count[i] <= (i < 6) ? s_tdata[8*i +: 8] : 8'd0;
            end
            target <= s_tdata[57:48];
            sum    <= '0;
            kind   <= '0;
            state  <= S_SUM;
          end
        end
        S_SUM: begin
          sum  <= sum + SUM_W'(a) * SUM_W'(c);
          kind <= kind + KIND_W'(1);
          if (int'(kind) == COIN_KINDS - 1) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          res_coins <= '0;
          if (sum >= SUM_W'(AMOUNT_LIMIT)) begin
            res_status <= STATUS_TOO_MUCH;
            state      <= S_DONE;
          end else if (SUM_W'(target) > sum) begin
            res_status <= STATUS_NO_PAY;
            state      <= S_DONE;
          end else begin
            j     <= '0;
            state <= S_INIT;
          end
        end
        S_INIT: begin
          j <= j + ADDR_W'(1);
          if (j == LAST_ADDR) begin
            kind  <= '0;
            state <= S_CH_KIND;
          end
        end
        S_CH_KIND: begin
          if (int'(kind) == COIN_KINDS) begin
            kind  <= '0;
            state <= S_PY_KIND;
          end else if ((a == 8'd0) || (OFF_W'(a) >= OFF_W'(AMOUNT_LIMIT))) begin
            kind <= kind + KIND_W'(1);
          end else begin
            j     <= ADDR_W'(a);
            state <= S_CH_RD;
          end
        end
        S_CH_RD: begin
          state <= S_CH_WR;
        end
        S_CH_WR: begin
          if (j == LAST_ADDR) begin
            kind  <= kind + KIND_W'(1);
            state <= S_CH_KIND;
          end else begin
            j     <= j + ADDR_W'(1);
            state <= S_CH_RD;
          end
        end
        S_PY_KIND: begin
          if (int'(kind) == COIN_KINDS) begin
            j     <= tgt;
            total <= '1;
            state <= S_SC_RD;
          end else if ((a == 8'd0) || (c == 8'd0)) begin
            kind <= kind + KIND_W'(1);
          end else begin
            j     <= top;
            state <= S_PY_RD0;
          end
        end
        S_PY_RD0: begin
          state <= S_PY_LD;
        end
        S_PY_LD: begin
          best  <= py_rdata;
          k     <= 9'd1;
          off   <= OFF_W'(a);
          state <= S_PY_K;
        end
        S_PY_K: begin
          if ((k <= {1'b0, c}) && (off <= OFF_W'(j))) begin
            state <= S_PY_ACC;
          end else if (j == '0) begin
            kind  <= kind + KIND_W'(1);
            state <= S_PY_KIND;
          end else begin
            j     <= j - ADDR_W'(1);
            state <= S_PY_RD0;
          end
        end
        S_PY_ACC: begin
          if ((py_rdata != UNREACHED) && (cand < {1'b0, best})) begin
            best <= cand[COST_W-1:0];
          end
          k     <= k + 9'd1;
          off   <= off + OFF_W'(a);
          state <= S_PY_K;
        end
        S_SC_RD: begin
          state <= S_SC_ACC;
        end
        S_SC_ACC: begin
          if ((py_rdata != UNREACHED) && (ch_rdata_b != UNREACHED) && (scan_sum < total)) begin
            total <= scan_sum;
          end
          if (j == top) begin
            state <= S_FIN;
          end else begin
            j     <= j + ADDR_W'(1);
            state <= S_SC_RD;
          end
        end
        S_FIN: begin
          if (total == '1) begin
            res_status <= STATUS_NO_PAY;
            res_coins  <= '0;
          end else begin
            res_status <= STATUS_OK;
            res_coins  <= (total > TOTAL_W'(MIN_COINS_MAX)) ? MIN_COINS_MAX
                                                            : total[COST_W-1:0];
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {5'd0, res_coins};
            m_tuser  <= res_status;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign s_tready = (state == S_IDLE);
  assign pready   = 1'b1;

  always_comb begin
    prdata = '0;
    if (int'(paddr[4:2]) < COIN_KINDS) begin
      prdata = {24'd0, coin_value[paddr[4:2]]};
    end
  end

endmodule
`default_nettype wire
